// File: rtl/les_pkg.sv
// Shared types, widths and constants for the largest empty square finder.
// No dependencies; used by les_ram's instantiation, les_cell and the top level.
`default_nettype none

package les_pkg;

    // Grid limits
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;

    // Field widths
    localparam int CHAR_W = 8;
    localparam int DIM_W  = 11;
    localparam int CNT_W  = 11;
    localparam int POS_W  = 10;
    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // Obstacle byte ('o')
    localparam logic [CHAR_W-1:0] OBSTACLE_CHAR = 8'h6F;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 2'd1;

    // Neighbor counts of the current cell, already zeroed at the grid edges
    typedef struct packed {
        logic [CNT_W-1:0] up;
        logic [CNT_W-1:0] left;
        logic [CNT_W-1:0] diag;
    } nbr_t;

    // Last column index for a written column register (0 acts as 1, clamp at max)
    function automatic logic [COL_W-1:0] last_col(input logic [DIM_W-1:0] v);
        logic [COL_W-1:0] r;
        if (v == '0) begin
            r = '0;
        end else if (32'(v) > MAX_COLUMNS) begin
            r = COL_W'(MAX_COLUMNS - 1);
        end else begin
            r = COL_W'(v - 1'b1);
        end
        return r;
    endfunction

    // Last row index for a written row register
    function automatic logic [ROW_W-1:0] last_row(input logic [DIM_W-1:0] v);
        logic [ROW_W-1:0] r;
        if (v == '0) begin
            r = '0;
        end else if (32'(v) > MAX_ROWS) begin
            r = ROW_W'(MAX_ROWS - 1);
        end else begin
            r = ROW_W'(v - 1'b1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/les_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module les_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/les_cell.sv
// Per-cell square count: zero for an obstacle, else one plus min of three neighbors.
// Depends on les_pkg.
`default_nettype none

module les_cell (
    input  wire logic [les_pkg::CHAR_W-1:0] cell_char,
    input  wire les_pkg::nbr_t              nbr,
    output logic      [les_pkg::CNT_W-1:0]  count
);

    logic [les_pkg::CNT_W-1:0] min_up_left;
    logic [les_pkg::CNT_W-1:0] min_all;

    // Take the minimum of up, left and diagonal
    always_comb begin
        min_up_left = (nbr.left < nbr.up) ? nbr.left : nbr.up;
        min_all     = (nbr.diag < min_up_left) ? nbr.diag : min_up_left;
    end

    // Obstacle blocks every square ending here
    assign count = (cell_char == les_pkg::OBSTACLE_CHAR) ? '0 : min_all + 1'b1;

endmodule

`default_nettype wire

// File: rtl/largest_empty_square_finder.sv
// Largest empty square finder: streams a grid in raster order, one cell per cycle while not stalled.
// Throughput: one cell per cycle; the grid's last cell stalls while an older result is not yet taken.
// Latency: the result is valid the cycle after the last cell's transfer.
// Previous-row counts sit in a MAX_COLUMNS-entry line store read one column ahead.
// Reset: grid is 1024 x 1024, scan and best square cleared; the line store is
// not cleared (its entries are always written in row 0 before their values are used).
`default_nettype none

module largest_empty_square_finder (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [les_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [les_pkg::DIM_W-1:0]       cfg_data,
    // Cell input channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [les_pkg::CHAR_W-1:0]      s_cell_char,
    // Result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_found,
    output logic      [les_pkg::CNT_W-1:0]       m_square_size,
    output logic      [les_pkg::POS_W-1:0]       m_square_left,
    output logic      [les_pkg::POS_W-1:0]       m_square_top
);

    localparam int COL_W = les_pkg::COL_W;
    localparam int ROW_W = les_pkg::ROW_W;
    localparam int CNT_W = les_pkg::CNT_W;
    localparam int POS_W = les_pkg::POS_W;

    // Grid size and scan position
    logic [COL_W-1:0] last_col_reg, last_col_next;
    logic [ROW_W-1:0] last_row_reg, last_row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // Running counts and best square
    logic [CNT_W-1:0] left_reg, left_next;
    logic [CNT_W-1:0] diag_reg, diag_next;
    logic [CNT_W-1:0] best_size_reg, best_size_next;
    logic [COL_W-1:0] best_right_reg, best_right_next;
    logic [ROW_W-1:0] best_bottom_reg, best_bottom_next;

    // Line store forwarding when the same column is read right after a write
    logic             byp_valid_reg, byp_valid_next;
    logic [CNT_W-1:0] byp_data_reg, byp_data_next;

    // Result register
    logic             m_valid_reg, m_valid_next;
    logic             m_found_reg, m_found_next;
    logic [CNT_W-1:0] m_size_reg, m_size_next;
    logic [POS_W-1:0] m_left_reg, m_left_next;
    logic [POS_W-1:0] m_top_reg, m_top_next;

    logic             cfg_fire;
    logic             cfg_hit;
    logic             s_fire;
    logic             at_last;
    logic [CNT_W-1:0] above_raw;
    logic [CNT_W-1:0] above_count;
    logic [CNT_W-1:0] cell_count;
    logic             new_best;
    les_pkg::nbr_t    nbr;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign cfg_hit   = cfg_fire & ((cfg_index == les_pkg::CFG_GRID_COLUMNS) ||
                                   (cfg_index == les_pkg::CFG_GRID_ROWS));

    // Stall only the grid's last cell while an older result still waits
    assign at_last = (col_reg == last_col_reg) && (row_reg == last_row_reg);
    assign s_ready = ~(m_valid_reg & ~m_ready & at_last);
    assign s_fire  = s_valid & s_ready;

    // Line store of previous-row counts
    les_ram #(
        .WIDTH (CNT_W),
        .DEPTH (les_pkg::MAX_COLUMNS),
        .ADDR_W(COL_W)
    ) u_line_store (
        .aclk   (aclk),
        .wr_en  (s_fire),
        .wr_addr(col_reg),
        .wr_data(cell_count),
        .rd_addr(col_next),
        .rd_data(above_raw)
    );

    // Gather the neighbors, zeroed on the top row and left column
    always_comb begin
        above_count = byp_valid_reg ? byp_data_reg : above_raw;
        nbr.up      = (row_reg == '0) ? '0 : above_count;
        nbr.left    = (col_reg == '0) ? '0 : left_reg;
        nbr.diag    = ((col_reg == '0) || (row_reg == '0)) ? '0 : diag_reg;
    end

    les_cell u_cell (
        .cell_char(s_cell_char),
        .nbr      (nbr),
        .count    (cell_count)
    );

    assign new_best = cell_count > best_size_reg;

    // Apply config writes, advance the scan, track the best square, emit the result at grid end
    always_comb begin
        last_col_next    = last_col_reg;
        last_row_next    = last_row_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        left_next        = left_reg;
        diag_next        = diag_reg;
        best_size_next   = best_size_reg;
        best_right_next  = best_right_reg;
        best_bottom_next = best_bottom_reg;
        byp_valid_next   = 1'b0;
        byp_data_next    = cell_count;
        m_valid_next     = m_valid_reg & ~m_ready;
        m_found_next     = m_found_reg;
        m_size_next      = m_size_reg;
        m_left_next      = m_left_reg;
        m_top_next       = m_top_reg;

        if (cfg_hit) begin
            // Apply the register and restart the grid
            case (cfg_index)
                les_pkg::CFG_GRID_COLUMNS: last_col_next = les_pkg::last_col(cfg_data);
                les_pkg::CFG_GRID_ROWS:    last_row_next = les_pkg::last_row(cfg_data);
                default: ;
            endcase
            col_next         = '0;
            row_next         = '0;
            left_next        = '0;
            diag_next        = '0;
            best_size_next   = '0;
            best_right_next  = '0;
            best_bottom_next = '0;
        end else if (s_fire) begin
            left_next = cell_count;
            diag_next = nbr.up;
            if (new_best) begin
                best_size_next   = cell_count;
                best_right_next  = col_reg;
                best_bottom_next = row_reg;
            end
            if (col_reg == last_col_reg) begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
            byp_valid_next = (col_next == col_reg);

            if (at_last) begin
                // Load the result and restart the grid
                m_valid_next = 1'b1;
                m_found_next = (best_size_next != '0);
                if (best_size_next != '0) begin
                    m_size_next = best_size_next;
                    m_left_next = POS_W'(CNT_W'(best_right_next) + 1'b1 - best_size_next);
                    m_top_next  = POS_W'(CNT_W'(best_bottom_next) + 1'b1 - best_size_next);
                end else begin
                    m_size_next = '0;
                    m_left_next = '0;
                    m_top_next  = '0;
                end
                row_next         = '0;
                left_next        = '0;
                diag_next        = '0;
                best_size_next   = '0;
                best_right_next  = '0;
                best_bottom_next = '0;
                byp_valid_next   = (col_next == col_reg);
            end
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg    <= COL_W'(les_pkg::MAX_COLUMNS - 1);
            last_row_reg    <= ROW_W'(les_pkg::MAX_ROWS - 1);
            col_reg         <= '0;
            row_reg         <= '0;
            left_reg        <= '0;
            diag_reg        <= '0;
            best_size_reg   <= '0;
            best_right_reg  <= '0;
            best_bottom_reg <= '0;
            byp_valid_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            last_col_reg    <= last_col_next;
            last_row_reg    <= last_row_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            left_reg        <= left_next;
            diag_reg        <= diag_next;
            best_size_reg   <= best_size_next;
            best_right_reg  <= best_right_next;
            best_bottom_reg <= best_bottom_next;
            byp_valid_reg   <= byp_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        byp_data_reg <= byp_data_next;
        m_found_reg  <= m_found_next;
        m_size_reg   <= m_size_next;
        m_left_reg   <= m_left_next;
        m_top_reg    <= m_top_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_square_size = m_size_reg;
    assign m_square_left = m_left_reg;
    assign m_square_top  = m_top_reg;

`ifndef SYNTHESIS
    // Scan position stays inside the configured grid
    a_col_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg <= last_col_reg) && (row_reg <= last_row_reg))
        else $error("scan position outside grid");

    // Last cell's transfer produces a result and restarts the scan
    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && at_last && !cfg_hit) |=>
            (m_valid_reg && (row_reg == '0) && (best_size_reg == '0)))
        else $error("grid end did not emit result");

    // Found flag agrees with the square size
    a_found_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_found_reg == (m_size_reg != '0)))
        else $error("found flag disagrees with size");

    // Best square never exceeds the grid's shorter side
    a_best_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (best_size_reg <= CNT_W'(row_reg) + 1'b1) &&
        (best_size_reg <= CNT_W'(last_col_reg) + 1'b1))
        else $error("best size out of bound");
`endif

endmodule

`default_nettype wire
